/* hdl/efil_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// Elias-Fano interval locator. No dependencies.
package efil_pkg;

  localparam int MaxEntries = 1024;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int LowAw      = $clog2(MaxEntries);
  localparam int LowW       = 31;
  localparam int UpperDepth = 3 * MaxEntries + 1;
  localparam int PosW       = $clog2(UpperDepth + 1);
  localparam int RowW       = 32;
  localparam int RowBw      = 5;
  localparam int NumRows    = (UpperDepth + RowW - 1) / RowW;
  localparam int RowAw      = $clog2(NumRows);

  // configuration register indexes
  localparam logic [1:0] CfgUniverse   = 2'd0;
  localparam logic [1:0] CfgLowerWidth = 2'd1;

  typedef enum logic [1:0] {
    KindLoad    = 2'd0,
    KindLocate  = 2'd1,
    KindBounds  = 2'd2,
    KindPresent = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBelowFirst = 3'd1,
    StBadNumber  = 3'd2,
    StOutOfOrder = 3'd3,
    StFull       = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SPrep, SLoadChk, SRankInit, SSelInit,
    SRowScan, SBitScan, SBackRd, SBackChk, SDone
  } state_e;

  typedef enum logic [3:0] {
    OpIdle, OpClear, OpCapture, OpPrep, OpLoadChk, OpRankInit, OpSelInit,
    OpRowScan, OpBitScan, OpBackRd, OpBackChk
  } op_e;

  // datapath status toward the controller
  typedef struct packed {
    logic  clr_last;
    kind_e kind;
    logic  prep_fail;
    logic  rank_scan;
    logic  row_hit;
    logic  bit_hit;
    logic  rank_mode;
    logic  sel_more;
    logic  back_go;
    logic  r_zero;
  } sts_t;

endpackage

/* hdl/efil_ctrl.sv */
// Controller state machine of the interval locator.
// Depends on efil_pkg; drives datapath operations from datapath status.
module efil_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  efil_pkg::sts_t   sts_i,
  output efil_pkg::op_e    op_o,
  output logic             busy_o,
  output logic             done_o
);

  efil_pkg::state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efil_pkg::SClear;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      efil_pkg::SClear: if (sts_i.clr_last) state_d = efil_pkg::SIdle;
      efil_pkg::SIdle: if (start_i) state_d = efil_pkg::SPrep;
      efil_pkg::SPrep: begin
        unique case (sts_i.kind)
          efil_pkg::KindLoad:
            state_d = sts_i.prep_fail ? efil_pkg::SDone : efil_pkg::SLoadChk;
          efil_pkg::KindBounds:
            state_d = sts_i.prep_fail ? efil_pkg::SDone : efil_pkg::SSelInit;
          default: state_d = efil_pkg::SRankInit;
        endcase
      end
      efil_pkg::SLoadChk: state_d = efil_pkg::SDone;
      efil_pkg::SRankInit:
        state_d = sts_i.rank_scan ? efil_pkg::SRowScan : efil_pkg::SBackRd;
      efil_pkg::SSelInit: state_d = efil_pkg::SRowScan;
      efil_pkg::SRowScan: if (sts_i.row_hit) state_d = efil_pkg::SBitScan;
      efil_pkg::SBitScan: begin
        if (sts_i.bit_hit) begin
          if (sts_i.rank_mode) state_d = efil_pkg::SBackRd;
          else if (sts_i.sel_more) state_d = efil_pkg::SSelInit;
          else state_d = efil_pkg::SDone;
        end
      end
      efil_pkg::SBackRd: begin
        if (sts_i.back_go) state_d = efil_pkg::SBackChk;
        else if (sts_i.r_zero) state_d = efil_pkg::SDone;
        else state_d = efil_pkg::SSelInit;
      end
      efil_pkg::SBackChk: state_d = efil_pkg::SBackRd;
      efil_pkg::SDone: state_d = efil_pkg::SIdle;
      default: state_d = efil_pkg::SIdle;
    endcase
  end

  // outputs
  always_comb begin
    op_o   = efil_pkg::OpIdle;
    busy_o = (state_q != efil_pkg::SIdle);
    done_o = (state_q == efil_pkg::SDone);
    unique case (state_q)
      efil_pkg::SClear:    op_o = efil_pkg::OpClear;
      efil_pkg::SIdle:     op_o = start_i ? efil_pkg::OpCapture : efil_pkg::OpIdle;
      efil_pkg::SPrep:     op_o = efil_pkg::OpPrep;
      efil_pkg::SLoadChk:  op_o = efil_pkg::OpLoadChk;
      efil_pkg::SRankInit: op_o = efil_pkg::OpRankInit;
      efil_pkg::SSelInit:  op_o = efil_pkg::OpSelInit;
      efil_pkg::SRowScan:  op_o = efil_pkg::OpRowScan;
      efil_pkg::SBitScan:  op_o = efil_pkg::OpBitScan;
      efil_pkg::SBackRd:   op_o = efil_pkg::OpBackRd;
      efil_pkg::SBackChk:  op_o = efil_pkg::OpBackChk;
      default:             op_o = efil_pkg::OpIdle;
    endcase
  end

endmodule

/* hdl/efil_dp.sv */
// Datapath of the interval locator: configuration, upper bit vector and lower
// store memories, row/bit select-scan unit and result registers. Uses efil_pkg.
module efil_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  efil_pkg::op_e             op_i,
  input  logic [1:0]                kind_i,
  input  logic [31:0]               value_i,
  input  logic [31:0]               range_low_i,
  input  logic [31:0]               range_high_i,
  input  logic [efil_pkg::CntW-1:0] interval_number_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [32:0]               cfg_data_i,
  output efil_pkg::sts_t            sts_o,
  output logic [efil_pkg::CntW-1:0] found_number_o,
  output logic [31:0]               interval_start_o,
  output logic [32:0]               interval_end_o,
  output logic                      is_present_o,
  output logic [2:0]                status_o
);

  localparam int CntW  = efil_pkg::CntW;
  localparam int PosW  = efil_pkg::PosW;
  localparam int RowAw = efil_pkg::RowAw;
  localparam int RowBw = efil_pkg::RowBw;
  localparam int RowW  = efil_pkg::RowW;
  localparam int LowAw = efil_pkg::LowAw;
  localparam int LowW  = efil_pkg::LowW;

  // memories
  logic [RowW-1:0] upper_mem [efil_pkg::NumRows];
  logic [LowW-1:0] lower_mem [efil_pkg::MaxEntries];
  logic [RowW-1:0] up_rd_q;
  logic [LowW-1:0] lo_rd_q;

  // control registers
  logic [32:0]      universe_q;
  logic [4:0]       lw_q;
  logic [CntW-1:0]  count_q;
  logic [31:0]      last_q;
  logic [RowAw-1:0] clr_q;

  // payload registers
  efil_pkg::kind_e   kind_q;
  efil_pkg::status_e status_q;
  logic [31:0]       value_q, rlo_q, rhi_q, k_q, start_q;
  logic [CntW-1:0]   num_q, found_q, ones_q;
  logic [PosW-1:0]   idx_q, tgt_q, cnt_q, c_q, pos_q;
  logic [RowAw-1:0]  row_q;
  logic [RowW-1:0]   rbuf_q;
  logic [RowBw-1:0]  bit_q;
  logic [32:0]       end_q;
  logic              pol_q, second_q, present_q;

  // combinational
  logic [31:0]       mask, kh, kl, dec;
  logic [32:0]       load_idx;
  logic              load_fail, num_bad, bit_set, row_hit, bit_hit;
  logic              back_go, back_more, sel_more, rank_scan;
  efil_pkg::status_e load_st;
  logic [PosW-1:0]   zt, cnt_next, hitpos, pm1, sel_tgt;
  logic [RowW-1:0]   match;
  logic [RowBw:0]    pc;
  logic              up_re, up_we, lo_re, lo_we;
  logic [RowAw-1:0]  up_ra, up_wa;
  logic [RowW-1:0]   up_wd;
  logic [LowAw-1:0]  lo_ra;

  assign mask     = ~(32'hFFFF_FFFF << lw_q);
  assign load_idx = {1'b0, value_q >> lw_q} + 33'(count_q);
  assign kh       = k_q >> lw_q;
  assign kl       = k_q & mask;
  assign zt       = PosW'(efil_pkg::UpperDepth) - PosW'(count_q);
  assign match    = pol_q ? up_rd_q : ~up_rd_q;
  assign pc       = (RowBw + 1)'($countones(match));
  assign cnt_next = cnt_q + PosW'(pc);
  assign row_hit  = cnt_next > tgt_q;
  assign bit_hit  = rbuf_q[0] && (c_q == '0);
  assign hitpos   = PosW'({row_q, bit_q});
  assign dec      = (32'(hitpos - tgt_q) << lw_q) | (32'(lo_rd_q) & mask);
  assign pm1      = pos_q - PosW'(1);
  assign back_go  = (pos_q != '0) && (ones_q != '0);
  assign back_more = up_rd_q[pm1[RowBw-1:0]] && (32'(lo_rd_q) > kl);
  assign sel_more = !second_q && (num_q < count_q);
  assign sel_tgt  = second_q ? PosW'(num_q) : PosW'(num_q - CntW'(1));
  assign bit_set  = up_rd_q[idx_q[RowBw-1:0]];
  assign num_bad  = (num_q == '0) || (num_q > count_q);
  assign rank_scan = (count_q != '0) && ({1'b0, k_q} < universe_q) &&
                     (kh < 32'(zt));

  // classify a load before touching the upper vector
  always_comb begin
    load_fail = 1'b1;
    load_st   = efil_pkg::StOk;
    priority if (count_q >= CntW'(efil_pkg::MaxEntries)) begin
      load_st = efil_pkg::StFull;
    end else if ((count_q != '0) && (value_q < last_q)) begin
      load_st = efil_pkg::StOutOfOrder;
    end else if (load_idx >= 33'(efil_pkg::UpperDepth)) begin
      load_st = efil_pkg::StFull;
    end else begin
      load_fail = 1'b0;
    end
  end

  // memory port control
  always_comb begin
    up_re = 1'b0;
    up_ra = '0;
    up_we = 1'b0;
    up_wa = idx_q[PosW-1:RowBw];
    up_wd = up_rd_q | (RowW'(1) << idx_q[RowBw-1:0]);
    lo_re = 1'b0;
    lo_ra = LowAw'(sel_tgt);
    lo_we = (op_i == efil_pkg::OpLoadChk) && !bit_set;
    unique case (op_i)
      efil_pkg::OpClear: begin
        up_we = 1'b1;
        up_wa = clr_q;
        up_wd = '0;
      end
      efil_pkg::OpPrep: begin
        up_re = (kind_q == efil_pkg::KindLoad) && !load_fail;
        up_ra = load_idx[PosW-1:RowBw];
      end
      efil_pkg::OpLoadChk: up_we = !bit_set;
      efil_pkg::OpRankInit: up_re = 1'b1;
      efil_pkg::OpSelInit: begin
        up_re = 1'b1;
        lo_re = 1'b1;
      end
      efil_pkg::OpRowScan: begin
        up_re = (32'(row_q) + 32'd1) < 32'(efil_pkg::NumRows);
        up_ra = row_q + RowAw'(1);
      end
      efil_pkg::OpBackRd: begin
        up_re = back_go;
        up_ra = pm1[PosW-1:RowBw];
        lo_re = back_go;
        lo_ra = LowAw'(ones_q - CntW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (up_we) upper_mem[up_wa] <= up_wd;
    if (up_re) up_rd_q <= upper_mem[up_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lo_we) lower_mem[LowAw'(count_q)] <= LowW'(value_q & mask);
    if (lo_re) lo_rd_q <= lower_mem[lo_ra];
  end

  // configuration, fill count and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      universe_q <= 33'h1_0000_0000;
      lw_q       <= '0;
      count_q    <= '0;
      last_q     <= '0;
      clr_q      <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == efil_pkg::CfgUniverse)) universe_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == efil_pkg::CfgLowerWidth)) lw_q <= cfg_data_i[4:0];
      if (op_i == efil_pkg::OpClear) clr_q <= clr_q + RowAw'(1);
      if ((op_i == efil_pkg::OpLoadChk) && !bit_set) begin
        count_q <= count_q + CntW'(1);
        last_q  <= value_q;
      end
    end
  end

  // item work
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      efil_pkg::OpCapture: begin
        kind_q    <= efil_pkg::kind_e'(kind_i);
        value_q   <= value_i;
        rlo_q     <= range_low_i;
        rhi_q     <= range_high_i;
        num_q     <= interval_number_i;
        second_q  <= 1'b0;
        found_q   <= '0;
        start_q   <= '0;
        end_q     <= '0;
        present_q <= 1'b0;
        status_q  <= efil_pkg::StOk;
      end
      efil_pkg::OpPrep: begin
        // midpoint of the range equals half the 33-bit sum
        k_q   <= (kind_q == efil_pkg::KindLocate) ?
                 32'(({1'b0, rlo_q} + {1'b0, rhi_q}) >> 1) : value_q;
        idx_q <= PosW'(load_idx);
        if (kind_q == efil_pkg::KindLoad) begin
          found_q <= count_q;
          if (load_fail) status_q <= load_st;
        end else if (kind_q == efil_pkg::KindBounds) begin
          found_q <= num_q;
          if (num_bad) status_q <= efil_pkg::StBadNumber;
        end
      end
      efil_pkg::OpLoadChk: begin
        if (bit_set) begin
          status_q <= efil_pkg::StOutOfOrder;
        end else begin
          found_q <= count_q + CntW'(1);
          start_q <= value_q;
        end
      end
      efil_pkg::OpRankInit: begin
        tgt_q <= PosW'(kh);
        pol_q <= 1'b0;
        cnt_q <= '0;
        row_q <= '0;
        ones_q <= count_q;
        // exactly as many zeros as the bucket index: scan back from the end
        pos_q  <= ((count_q != '0) && ({1'b0, k_q} < universe_q) && (kh == 32'(zt))) ?
                  PosW'(efil_pkg::UpperDepth) : '0;
      end
      efil_pkg::OpSelInit: begin
        tgt_q <= sel_tgt;
        pol_q <= 1'b1;
        cnt_q <= '0;
        row_q <= '0;
      end
      efil_pkg::OpRowScan: begin
        if (row_hit) begin
          rbuf_q <= match;
          bit_q  <= '0;
          c_q    <= tgt_q - cnt_q;
        end else begin
          cnt_q <= cnt_next;
          row_q <= row_q + RowAw'(1);
        end
      end
      efil_pkg::OpBitScan: begin
        if (bit_hit) begin
          if (!pol_q) begin
            pos_q  <= hitpos;
            ones_q <= CntW'(hitpos - tgt_q);
          end else if (!second_q) begin
            start_q   <= dec;
            present_q <= (kind_q == efil_pkg::KindPresent) && (dec == value_q);
            if (sel_more) second_q <= 1'b1;
            else end_q <= universe_q;
          end else begin
            end_q <= {1'b0, dec};
          end
        end else begin
          rbuf_q <= rbuf_q >> 1;
          bit_q  <= bit_q + RowBw'(1);
          if (rbuf_q[0]) c_q <= c_q - PosW'(1);
        end
      end
      efil_pkg::OpBackRd: begin
        if (!back_go) begin
          found_q <= ones_q;
          num_q   <= ones_q;
          if (ones_q == '0) status_q <= efil_pkg::StBelowFirst;
        end
      end
      efil_pkg::OpBackChk: begin
        // drop one entry while its low bits sit above the key
        if (back_more) begin
          ones_q <= ones_q - CntW'(1);
          pos_q  <= pm1;
        end else begin
          pos_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    sts_o.clr_last  = (clr_q == RowAw'(efil_pkg::NumRows - 1));
    sts_o.kind      = kind_q;
    sts_o.prep_fail = (kind_q == efil_pkg::KindLoad) ? load_fail : num_bad;
    sts_o.rank_scan = rank_scan;
    sts_o.row_hit   = row_hit;
    sts_o.bit_hit   = bit_hit;
    sts_o.rank_mode = !pol_q;
    sts_o.sel_more  = sel_more;
    sts_o.back_go   = back_go;
    sts_o.r_zero    = (ones_q == '0);
  end

  assign found_number_o   = found_q;
  assign interval_start_o = start_q;
  assign interval_end_o   = end_q;
  assign is_present_o     = present_q;
  assign status_o         = status_q;

endmodule

/* hdl/elias_fano_interval_locator.sv */
// Top level of the Elias-Fano interval locator: controller plus datapath.
// Depends on efil_pkg, efil_ctrl and efil_dp.
//
//   channel   handshake                 payload
//   command   start_i / busy_o          kind_i value_i range_low_i range_high_i
//                                       interval_number_i
//   result    done_o (one-cycle strobe) found_number_o interval_start_o
//                                       interval_end_o is_present_o status_o
//   config    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// One item at a time. A load runs a prep state and, unless refused there, a check
// state. A query runs a select or rank scan over the upper bit vector, one 32-bit
// row per cycle and then one bit per cycle in the hit row, plus a read and a check
// state per step of the backward scan; bounds take up to two selects, locate and
// presence one rank and up to two selects. After reset a clearing pass holds
// busy_o high. Results cannot be stalled: each shows for one cycle with done_o.
module elias_fano_interval_locator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic [10:0] interval_number_i,
  output logic        done_o,
  output logic [10:0] found_number_o,
  output logic [31:0] interval_start_o,
  output logic [32:0] interval_end_o,
  output logic        is_present_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i
);

  efil_pkg::op_e  op;
  efil_pkg::sts_t sts;

  // config writes are never stalled
  assign cfg_ready_o = 1'b1;

  efil_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .op_o   (op),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  efil_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .range_low_i      (range_low_i),
    .range_high_i     (range_high_i),
    .interval_number_i(interval_number_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sts_o            (sts),
    .found_number_o   (found_number_o),
    .interval_start_o (interval_start_o),
    .interval_end_o   (interval_end_o),
    .is_present_o     (is_present_o),
    .status_o         (status_o)
  );

  // an accepted item keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // a result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a miss below the first entry reports no interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == 3'(efil_pkg::StBelowFirst))) |->
      ((found_number_o == '0) && (interval_start_o == '0) && !is_present_o))
    else $error("below-first result carries data");

endmodule
